// ===== hdl/bis_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
package bis_pkg;

	localparam int PIX_W = 24;
	localparam int CHAN_W = 8;
	localparam int FRAC_W = 16;
	localparam int POS_W = 10;
	localparam int STEP_W = 24;
	localparam int SRC_W = POS_W + STEP_W;

	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

	typedef enum logic [1:0] {
		CFG_IN_WIDTH,
		CFG_IN_HEIGHT,
		CFG_X_STEP,
		CFG_Y_STEP
	} cfg_idx_t;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
	} req_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_a;
		logic [CHAN_W-1:0] out_b;
		logic [CHAN_W-1:0] out_c;
	} rsp_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0] p00;
		logic [CHAN_W-1:0] p01;
		logic [CHAN_W-1:0] p10;
		logic [CHAN_W-1:0] p11;
	} nbr_t;

endpackage

// ===== hdl/bis_bank.sv =====
// One bank of the frame store with a write port and a registered read port.
module bis_bank
	import bis_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== hdl/bis_axis.sv =====
// Maps a scaled source position to base index, next index and fraction on one axis.
module bis_axis
	import bis_pkg::*;
#(
	parameter int IW = 6
) (
	input  logic [SRC_W-1:0]  src,
	input  logic [IW-1:0]     dim_m1,
	output logic [IW-1:0]     idx0,
	output logic [IW-1:0]     idx1,
	output logic [FRAC_W-1:0] frac
);

	localparam int IP_W = SRC_W - FRAC_W;

	logic [IP_W-1:0] ip;
	logic [IP_W-1:0] lim;

	always_comb begin
		ip = src[SRC_W-1:FRAC_W];
		lim = IP_W'(dim_m1);
		if (ip >= lim) begin
			idx0 = dim_m1;
		end else begin
			idx0 = IW'(ip);
		end
		if (ip > lim) begin
			frac = '0;
		end else begin
			frac = src[FRAC_W-1:0];
		end
		if (idx0 < dim_m1) begin
			idx1 = idx0 + IW'(1);
		end else begin
			idx1 = dim_m1;
		end
	end

endmodule

// ===== hdl/bis_lane.sv =====
// One channel lane: horizontal blend in a register stage, then vertical blend.
module bis_lane
	import bis_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  nbr_t              nbr,
	input  logic [FRAC_W-1:0] frac_x,
	input  logic [FRAC_W-1:0] frac_y,
	output logic [CHAN_W-1:0] value
);

	localparam int ROW_W = CHAN_W + FRAC_W;
	localparam int ACC_W = ROW_W + FRAC_W + 1;

	logic [FRAC_W:0]   wx;
	logic [FRAC_W:0]   wy;
	logic [ROW_W:0]    top_sum;
	logic [ROW_W:0]    bot_sum;
	logic [ROW_W-1:0]  top_s3;
	logic [ROW_W-1:0]  bot_s3;
	logic [FRAC_W-1:0] fy_s3;
	logic [ACC_W-1:0]  acc;

	always_comb begin
		wx = FRAC_ONE - {1'b0, frac_x};
		top_sum = (ROW_W+1)'(nbr.p00) * (ROW_W+1)'(wx)
			+ (ROW_W+1)'(nbr.p01) * (ROW_W+1)'(frac_x);
		bot_sum = (ROW_W+1)'(nbr.p10) * (ROW_W+1)'(wx)
			+ (ROW_W+1)'(nbr.p11) * (ROW_W+1)'(frac_x);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s3 <= ROW_W'(top_sum);
			bot_s3 <= ROW_W'(bot_sum);
			fy_s3 <= frac_y;
		end
	end

	always_comb begin
		wy = FRAC_ONE - {1'b0, fy_s3};
		acc = ACC_W'(top_s3) * ACC_W'(wy) + ACC_W'(bot_s3) * ACC_W'(fy_s3);
		value = acc[2*FRAC_W +: CHAN_W];
	end

endmodule

// ===== hdl/bilinear_image_scaler_unit.sv =====
// Top level of the bilinear image scaler: frame store banks, mapping, lanes and output.
//
//  channel | signals                                  | moves
//  req     | req_valid, req_ready, req_data           | store or fetch word in
//  rsp     | rsp_valid, rsp_ready, rsp_data           | interpolated pixel word out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write word in
//
// One word is accepted per cycle while req_ready is high.
// The rate is set by four frame store banks split on row and column parity, so the
// four neighbours of a fetch are read in the same cycle.
// Reset clears pipeline valid bits and loads the register defaults; the frame store
// is not cleared and needs no clearing pass.
// A stall on rsp holds each stage only while the stage after it is full.
module bilinear_image_scaler_unit
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_word_t           req_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_word_t           rsp_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cfg_idx_t            cfg_index,
	input  logic [STEP_W-1:0]   cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int HALF_W = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int DIM_W = 11;

	function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] col,
		input logic [YW-1:0] row);
		logic [31:0] a;
		a = 32'(row >> 1) * 32'(HALF_W) + 32'(col >> 1);
		return AW'(a);
	endfunction

	logic [6:0]        in_width_q;
	logic [6:0]        in_height_q;
	logic [STEP_W-1:0] x_step_q;
	logic [STEP_W-1:0] y_step_q;

	logic [DIM_W-1:0] w_ext;
	logic [DIM_W-1:0] h_ext;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [XW-1:0]    w_m1;
	logic [YW-1:0]    h_m1;

	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic adv_out;

	logic              v_s1;
	logic              kind_s1;
	logic [SRC_W-1:0]  src_x_s1;
	logic [SRC_W-1:0]  src_y_s1;
	logic              st_ok_s1;
	logic [XW-1:0]     st_x_s1;
	logic [YW-1:0]     st_y_s1;
	logic [PIX_W-1:0]  st_pix_s1;

	logic [XW-1:0]     x0;
	logic [XW-1:0]     x1;
	logic [YW-1:0]     y0;
	logic [YW-1:0]     y1;
	logic [FRAC_W-1:0] fx;
	logic [FRAC_W-1:0] fy;

	logic [AW-1:0]    rd_addr [4];
	logic [AW-1:0]    wr_addr;
	logic             wr_en [4];
	logic [PIX_W-1:0] bank_rd [4];

	logic              v_s2;
	logic [FRAC_W-1:0] fx_s2;
	logic [FRAC_W-1:0] fy_s2;
	logic [3:0]        par_s2;

	logic [PIX_W-1:0] q00;
	logic [PIX_W-1:0] q01;
	logic [PIX_W-1:0] q10;
	logic [PIX_W-1:0] q11;
	nbr_t             nbr_a;
	nbr_t             nbr_b;
	nbr_t             nbr_c;

	logic              v_s3;
	logic [CHAN_W-1:0] lane_a;
	logic [CHAN_W-1:0] lane_b;
	logic [CHAN_W-1:0] lane_c;

	logic      rsp_valid_q;
	rsp_word_t rsp_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q <= 7'd64;
			in_height_q <= 7'd64;
			x_step_q <= 24'h010000;
			y_step_q <= 24'h010000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IN_WIDTH: in_width_q <= cfg_data[6:0];
				CFG_IN_HEIGHT: in_height_q <= cfg_data[6:0];
				CFG_X_STEP: x_step_q <= cfg_data;
				CFG_Y_STEP: y_step_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		w_ext = DIM_W'(in_width_q);
		h_ext = DIM_W'(in_height_q);
		if (w_ext == '0) begin
			w_eff = DIM_W'(1);
		end else if (w_ext > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext == '0) begin
			h_eff = DIM_W'(1);
		end else if (h_ext > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
		w_m1 = XW'(w_eff - DIM_W'(1));
		h_m1 = YW'(h_eff - DIM_W'(1));
	end

	assign adv_out = !rsp_valid_q || rsp_ready;
	assign rdy3 = !v_s3 || adv_out;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= req_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && (kind_s1 == KIND_FETCH);
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				rsp_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1 <= req_data.kind;
			src_x_s1 <= SRC_W'(req_data.pos_x) * SRC_W'(x_step_q);
			src_y_s1 <= SRC_W'(req_data.pos_y) * SRC_W'(y_step_q);
			st_ok_s1 <= (DIM_W'(req_data.pos_x) < w_eff) && (DIM_W'(req_data.pos_y) < h_eff);
			st_x_s1 <= XW'(req_data.pos_x);
			st_y_s1 <= YW'(req_data.pos_y);
			st_pix_s1 <= {req_data.chan_c, req_data.chan_b, req_data.chan_a};
		end
	end

	bis_axis #(.IW(XW)) u_axis_x (
		.src(src_x_s1),
		.dim_m1(w_m1),
		.idx0(x0),
		.idx1(x1),
		.frac(fx)
	);

	bis_axis #(.IW(YW)) u_axis_y (
		.src(src_y_s1),
		.dim_m1(h_m1),
		.idx0(y0),
		.idx1(y1),
		.frac(fy)
	);

	always_comb begin
		wr_addr = bank_addr(st_x_s1, st_y_s1);
		for (int b = 0; b < 4; b++) begin
			rd_addr[b] = bank_addr((x0[0] == b[0]) ? x0 : x1, (y0[0] == b[1]) ? y0 : y1);
			wr_en[b] = rdy2 && v_s1 && (kind_s1 == KIND_STORE) && st_ok_s1
				&& (st_x_s1[0] == b[0]) && (st_y_s1[0] == b[1]);
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		bis_bank #(.DEPTH(BANK_DEPTH), .AW(AW)) u_bank (
			.clk(clk),
			.wr_en(wr_en[g]),
			.wr_addr(wr_addr),
			.wr_data(st_pix_s1),
			.rd_en(rdy2),
			.rd_addr(rd_addr[g]),
			.rd_data(bank_rd[g])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			fx_s2 <= fx;
			fy_s2 <= fy;
			par_s2 <= {y1[0], y0[0], x1[0], x0[0]};
		end
	end

	always_comb begin
		q00 = bank_rd[{par_s2[2], par_s2[0]}];
		q01 = bank_rd[{par_s2[2], par_s2[1]}];
		q10 = bank_rd[{par_s2[3], par_s2[0]}];
		q11 = bank_rd[{par_s2[3], par_s2[1]}];
		nbr_a = '{p00: q00[7:0], p01: q01[7:0], p10: q10[7:0], p11: q11[7:0]};
		nbr_b = '{p00: q00[15:8], p01: q01[15:8], p10: q10[15:8], p11: q11[15:8]};
		nbr_c = '{p00: q00[23:16], p01: q01[23:16], p10: q10[23:16], p11: q11[23:16]};
	end

	bis_lane u_lane_a (
		.clk(clk), .en(rdy3), .nbr(nbr_a), .frac_x(fx_s2), .frac_y(fy_s2), .value(lane_a)
	);

	bis_lane u_lane_b (
		.clk(clk), .en(rdy3), .nbr(nbr_b), .frac_x(fx_s2), .frac_y(fy_s2), .value(lane_b)
	);

	bis_lane u_lane_c (
		.clk(clk), .en(rdy3), .nbr(nbr_c), .frac_x(fx_s2), .frac_y(fy_s2), .value(lane_c)
	);

	always_ff @(posedge clk) begin
		if (adv_out) begin
			rsp_data_q <= '{out_a: lane_a, out_b: lane_b, out_c: lane_c};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req_ready)
		else $error("Input stalled while the output register is empty.");

	a_next_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (kind_s1 == KIND_FETCH) |-> (x1 <= w_m1) && (y1 <= h_m1))
		else $error("Neighbor index beyond the last column or row.");

	a_stage3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy3 |=> v_s3)
		else $error("Stalled word lost in the lane stage.");

endmodule

// ===== bench/bilinear_image_scaler_checker.sv =====
// Checker of the bilinear image scaler: watches the channels, predicts every pixel and compares.
`timescale 1ns / 100ps

module bilinear_image_scaler_checker
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  req_word_t         req_data,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  rsp_word_t         rsp_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  cfg_idx_t          cfg_index,
	input  logic [STEP_W-1:0] cfg_data,
	output int                errors,
	output int                pending
);

	localparam logic [6:0] DIM_RESET = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;
	localparam int SHOWN_MAX = 10;

	logic [PIX_W-1:0] pixels [MAX_WIDTH*MAX_HEIGHT];
	logic [6:0] width_reg;
	logic [6:0] height_reg;
	logic [STEP_W-1:0] x_step_reg;
	logic [STEP_W-1:0] y_step_reg;
	rsp_word_t expected_pixels [$];
	int mismatch_count;

	function automatic int eff_dim(input logic [6:0] raw, input int limit);
		if (raw == 0)
			return 1;
		return (int'(raw) > limit) ? limit : int'(raw);
	endfunction

	function automatic void map_axis(input logic [POS_W-1:0] pos, input logic [STEP_W-1:0] step,
		input int dim, output int i0, output int i1, output logic [FRAC_W:0] frac);
		logic [SRC_W-1:0] src;
		logic [SRC_W-1:0] ip;
		src = SRC_W'(pos) * SRC_W'(step);
		ip = src >> FRAC_W;
		frac = {1'b0, src[FRAC_W-1:0]};
		if (ip >= SRC_W'(dim - 1)) begin
			if (ip > SRC_W'(dim - 1))
				frac = '0;
			i0 = dim - 1;
		end else begin
			i0 = int'(ip);
		end
		i1 = (i0 + 1 < dim) ? i0 + 1 : dim - 1;
	endfunction

	function automatic rsp_word_t blend_pixel(input req_word_t w);
		int x0, x1, y0, y1;
		logic [FRAC_W:0] fx, fy;
		logic [2*FRAC_W+1:0] wt [4];
		logic [PIX_W-1:0] nb [4];
		logic [47:0] acc;
		logic [CHAN_W-1:0] chans [3];
		rsp_word_t r;
		map_axis(w.pos_x, x_step_reg, eff_dim(width_reg, MAX_WIDTH), x0, x1, fx);
		map_axis(w.pos_y, y_step_reg, eff_dim(height_reg, MAX_HEIGHT), y0, y1, fy);
		wt[0] = (FRAC_ONE - fx) * (FRAC_ONE - fy);
		wt[1] = fx * (FRAC_ONE - fy);
		wt[2] = (FRAC_ONE - fx) * fy;
		wt[3] = fx * fy;
		nb[0] = pixels[y0*MAX_WIDTH + x0];
		nb[1] = pixels[y0*MAX_WIDTH + x1];
		nb[2] = pixels[y1*MAX_WIDTH + x0];
		nb[3] = pixels[y1*MAX_WIDTH + x1];
		for (int c = 0; c < 3; c++) begin
			acc = '0;
			for (int k = 0; k < 4; k++)
				acc += wt[k] * nb[k][CHAN_W*c +: CHAN_W];
			chans[c] = acc[2*FRAC_W +: CHAN_W];
		end
		r.out_a = chans[0];
		r.out_b = chans[1];
		r.out_c = chans[2];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			width_reg = DIM_RESET;
			height_reg = DIM_RESET;
			x_step_reg = STEP_RESET;
			y_step_reg = STEP_RESET;
			expected_pixels.delete();
			mismatch_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IN_WIDTH: width_reg = cfg_data[6:0];
					CFG_IN_HEIGHT: height_reg = cfg_data[6:0];
					CFG_X_STEP: x_step_reg = cfg_data;
					CFG_Y_STEP: y_step_reg = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_MAX)
						$display("%0t: unexpected pixel word a=%02h b=%02h c=%02h", $realtime,
							rsp_data.out_a, rsp_data.out_b, rsp_data.out_c);
				end else begin
					want = expected_pixels.pop_front();
					if (rsp_data.out_a !== want.out_a || rsp_data.out_b !== want.out_b ||
						rsp_data.out_c !== want.out_c) begin
						mismatch_count++;
						if (mismatch_count <= SHOWN_MAX)
							$display("%0t: pixel mismatch, expected a=%02h b=%02h c=%02h, got a=%02h b=%02h c=%02h",
								$realtime, want.out_a, want.out_b, want.out_c,
								rsp_data.out_a, rsp_data.out_b, rsp_data.out_c);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.kind == KIND_STORE) begin
					if (int'(req_data.pos_x) < eff_dim(width_reg, MAX_WIDTH) &&
						int'(req_data.pos_y) < eff_dim(height_reg, MAX_HEIGHT))
						pixels[int'(req_data.pos_y)*MAX_WIDTH + int'(req_data.pos_x)] =
							{req_data.chan_c, req_data.chan_b, req_data.chan_a};
				end else begin
					expected_pixels.push_back(blend_pixel(req_data));
				end
			end
			errors <= mismatch_count;
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== bench/bilinear_image_scaler_unit_test.sv =====
// Testbench top of the bilinear image scaler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module bilinear_image_scaler_unit_test;
	import bis_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int RANDOM_ITEMS = 1500;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_WAIT = 17;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_IN_WIDTH;
	logic [STEP_W-1:0] cfg_data = '0;
	int errors;
	int pending;

	int send_mode = 0;
	int recv_mode = 0;
	int sent_words = 0;
	bit hold_req = 1'b0;
	logic hold_off = 1'b0;
	bit written [MAX_W*MAX_H];
	int cur_w = 64;
	int cur_h = 64;
	logic [STEP_W-1:0] cur_xs = 24'h010000;
	logic [STEP_W-1:0] cur_ys = 24'h010000;

	bilinear_image_scaler_unit #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bilinear_image_scaler_checker #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, MAX_WAIT);
			default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
		endcase
	endfunction

	function automatic int clamp_dim(input logic [6:0] raw, input int limit);
		if (raw == 0)
			return 1;
		return (int'(raw) > limit) ? limit : int'(raw);
	endfunction

	function automatic void src_span(input int pos, input logic [STEP_W-1:0] step, input int dim,
		output int lo, output int hi);
		logic [SRC_W-1:0] ip;
		ip = (SRC_W'(pos) * SRC_W'(step)) >> FRAC_W;
		lo = (ip >= SRC_W'(dim - 1)) ? dim - 1 : int'(ip);
		hi = (lo + 1 < dim) ? lo + 1 : dim - 1;
	endfunction

	function automatic logic [6:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 7'($urandom_range(1, 8));
		if (r < 8)
			return 7'($urandom_range(9, 64));
		case ($urandom_range(0, 3))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd64;
			default: return 7'($urandom_range(65, 127));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 24'h010000;
			2: return 24'hFFFFFF;
			3, 4, 5: return STEP_W'($urandom_range(24'h000800, 24'h020000));
			default: return STEP_W'($urandom);
		endcase
	endfunction

	function automatic int pick_pos(input logic [STEP_W-1:0] step, input int dim);
		int lim;
		if (step == 0 || $urandom_range(0, 3) == 0)
			return $urandom_range(0, 1023);
		lim = ((dim + 1) * 65536) / int'(step);
		return $urandom_range(0, (lim > 1023) ? 1023 : lim);
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		gap = draw_wait(send_mode);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= w;
		do @(posedge clk); while (!req_ready);
		sent_words++;
	endtask

	task automatic store_at(input int x, input int y, input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] c);
		req_word_t w;
		w.kind = KIND_STORE;
		w.pos_x = POS_W'(x);
		w.pos_y = POS_W'(y);
		w.chan_a = a;
		w.chan_b = b;
		w.chan_c = c;
		send_word(w);
		if (x < cur_w && y < cur_h)
			written[y*MAX_W + x] = 1'b1;
	endtask

	task automatic store_random(input int x, input int y);
		store_at(x, y, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
	endtask

	// Any neighbor not yet written is stored first, so no fetch reads an unwritten entry.
	task automatic fetch_at(input int px, input int py);
		int xl, xh, yl, yh, xx, yy;
		req_word_t w;
		src_span(px, cur_xs, cur_w, xl, xh);
		src_span(py, cur_ys, cur_h, yl, yh);
		for (int j = 0; j < 2; j++) begin
			for (int i = 0; i < 2; i++) begin
				xx = (i == 0) ? xl : xh;
				yy = (j == 0) ? yl : yh;
				if (!written[yy*MAX_W + xx])
					store_random(xx, yy);
			end
		end
		w.kind = KIND_FETCH;
		w.pos_x = POS_W'(px);
		w.pos_y = POS_W'(py);
		w.chan_a = CHAN_W'($urandom);
		w.chan_b = CHAN_W'($urandom);
		w.chan_c = CHAN_W'($urandom);
		send_word(w);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [STEP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [6:0] raw_w, input logic [6:0] raw_h,
		input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys);
		write_reg(CFG_IN_WIDTH, {17'($urandom), raw_w});
		write_reg(CFG_IN_HEIGHT, {17'($urandom), raw_h});
		write_reg(CFG_X_STEP, xs);
		write_reg(CFG_Y_STEP, ys);
		cfg_valid <= 1'b0;
		cur_w = clamp_dim(raw_w, MAX_W);
		cur_h = clamp_dim(raw_h, MAX_H);
		cur_xs = xs;
		cur_ys = ys;
	endtask

	task automatic finish_phase();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				stall = draw_wait(recv_mode);
			if (hold_off || stall > 0) begin
				rsp_ready <= 1'b0;
				if (!hold_off)
					stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int phase, count, sel, px, py;
		phase = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		store_at(0, 0, 8'hFF, 8'h00, 8'hFF);
		store_at(1, 0, 8'h00, 8'hFF, 8'h00);
		store_at(0, 1, 8'h80, 8'h7F, 8'h01);
		store_at(1, 1, 8'hFE, 8'h01, 8'hAA);
		fetch_at(0, 0);
		store_at(63, 63, 8'hFF, 8'hFF, 8'hFF);
		fetch_at(63, 63);
		fetch_at(1023, 1023);
		store_at(64, 0, 8'h11, 8'h22, 8'h33);
		store_at(0, 1023, 8'h44, 8'h55, 8'h66);
		fetch_at(63, 0);
		finish_phase();

		set_config(7'd0, 7'd127, 24'hFFFFFF, 24'h008000);
		store_at(1, 0, 8'h77, 8'h88, 8'h99);
		fetch_at(0, 127);
		fetch_at(1023, 1);
		finish_phase();

		set_config(7'd5, 7'd3, 24'h008000, 24'h000000);
		fetch_at(9, 5);
		fetch_at(3, 1023);
		fetch_at(10, 0);
		finish_phase();

		set_config(7'd64, 7'd1, 24'h018000, 24'hFFFFFF);
		fetch_at(42, 7);
		fetch_at(41, 0);
		finish_phase();

		while (sent_words < RANDOM_ITEMS) begin
			set_config(pick_dim(), pick_dim(), pick_step(), pick_step());
			send_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
			recv_mode = (phase == 0) ? 1 : $urandom_range(0, 2);
			if (phase == 0)
				hold_req = 1'b1;
			count = $urandom_range(60, 200);
			repeat (count) begin
				sel = $urandom_range(0, 19);
				if (sel < 9) begin
					fetch_at(pick_pos(cur_xs, cur_w), pick_pos(cur_ys, cur_h));
				end else if (sel < 18) begin
					store_random($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
				end else begin
					px = $urandom_range(0, 1023);
					py = $urandom_range(0, 1023);
					store_random(px, py);
				end
			end
			finish_phase();
			phase++;
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
